// File: rtl/pcmmix_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcmmix_pkg;

  localparam int VOICE_W = 4;
  localparam int ADDR_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 16;
  localparam int RATE_W  = 16;
  localparam int VOL_W   = 7;
  localparam int SEP_W   = 8;
  localparam int SAMP_W  = 16;
  localparam int MASK_W  = 16;
  localparam int GAIN_W  = 8;
  localparam int FRAC_W  = 16;
  localparam int POS_W   = 32;
  localparam int DIV_W   = 32;

  localparam int SEP_MAX      = 254;
  localparam int GAIN_DIV     = 127;
  localparam int DEFAULT_RATE = 11025;
  localparam int SAT_MAX      = 32767;
  localparam int SAT_MIN      = -32768;

  typedef enum logic [2:0] {
    CMD_LOAD  = 3'd0,
    CMD_START = 3'd1,
    CMD_SET   = 3'd2,
    CMD_STOP  = 3'd3,
    CMD_MIX   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    DIV_STEP,
    DIV_LEFT,
    DIV_RIGHT
  } div_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STEP,
    ST_LGAIN,
    ST_RGAIN,
    ST_ADDR,
    ST_VREAD,
    ST_VCHECK,
    ST_VMOD,
    ST_SREAD,
    ST_MUL,
    ST_ACC,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic     accept;
    logic     div_go;
    div_sel_e div_sel;
    logic     mod_go;
    logic     mod_voice;
    logic     pos_wr;
    logic     clr_active;
    logic     v_next;
    logic     mul_en;
    logic     acc_en;
    logic     fin;
  } ctl_t;

  typedef struct packed {
    logic [2:0] cmd_in;
    logic       count_zero_in;
    logic       voice_ok_in;
    logic       div_done;
    logic       mod_done;
    logic       cur_active;
    logic       expired;
    logic       last_voice;
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/multi_voice_pcm_mixer_core.sv
// A start finds the step and both pan gains and a set both gains, each quotient by a reciprocal
// multiply; a load wraps its address. Stop and unused commands go straight to the finish state.
// A mix frame skips each idle voice, clears each voice that has run out, and reads, scales and
// accumulates each playing voice (one sample store port, serial address wrap).
// One request at a time; the next is taken in the cycle its predecessor's strobe shows.
// Reset makes every voice inactive; the sample store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module multi_voice_pcm_mixer_core
  import pcmmix_pkg::*;
#(
  parameter int VOICES       = 16,
  parameter int SAMPLE_DEPTH = 65536,
  parameter int OUTPUT_RATE  = 48000
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       start,
  output logic                      busy,
  input  wire         [2:0]         cmd_i,
  input  wire         [VOICE_W-1:0] voice_i,
  input  wire         [ADDR_W-1:0]  address_i,
  input  wire         [BYTE_W-1:0]  byte_value_i,
  input  wire         [COUNT_W-1:0] sample_count_i,
  input  wire         [RATE_W-1:0]  native_rate_i,
  input  wire         [VOL_W-1:0]   volume_i,
  input  wire         [SEP_W-1:0]   separation_i,
  output logic signed [SAMP_W-1:0]  left_out_o,
  output logic signed [SAMP_W-1:0]  right_out_o,
  output logic                      status_o,
  output logic        [MASK_W-1:0]  active_mask_o,
  output logic                      result_valid_o
);

  ctl_t  ctl;
  stat_t stat;

  pcmmix_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  pcmmix_dp #(
    .VOICES       (VOICES),
    .SAMPLE_DEPTH (SAMPLE_DEPTH),
    .OUTPUT_RATE  (OUTPUT_RATE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .stat_o         (stat),
    .cmd_i          (cmd_i),
    .voice_i        (voice_i),
    .address_i      (address_i),
    .byte_value_i   (byte_value_i),
    .sample_count_i (sample_count_i),
    .native_rate_i  (native_rate_i),
    .volume_i       (volume_i),
    .separation_i   (separation_i),
    .left_out_o     (left_out_o),
    .right_out_o    (right_out_o),
    .status_o       (status_o),
    .active_mask_o  (active_mask_o),
    .result_valid_o (result_valid_o)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted request did not make the block busy");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe lasted more than one cycle");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while still busy");

  a_reject_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o |-> (left_out_o == '0) && (right_out_o == '0))
    else $error("rejected start produced mix output");

endmodule

`default_nettype wire

// File: rtl/pcmmix_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pcmmix_ctrl
  import pcmmix_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   start,
  output logic  busy,
  input  stat_t stat_i,
  output ctl_t  ctl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          ctl_o.accept = 1'b1;
          case (stat_i.cmd_in)
            CMD_LOAD: begin
              state_d = ST_ADDR;
            end
            CMD_START: begin
              if (stat_i.count_zero_in || !stat_i.voice_ok_in) begin
                state_d = ST_FIN;
              end else begin
                state_d = ST_STEP;
              end
            end
            CMD_SET: begin
              state_d = stat_i.voice_ok_in ? ST_LGAIN : ST_FIN;
            end
            CMD_MIX: begin
              state_d = ST_VREAD;
            end
            default: begin
              state_d = ST_FIN;
            end
          endcase
        end
      end
      ST_STEP: begin
        ctl_o.div_go  = 1'b1;
        ctl_o.div_sel = DIV_STEP;
        if (stat_i.div_done) begin
          state_d = ST_LGAIN;
        end
      end
      ST_LGAIN: begin
        ctl_o.div_go  = 1'b1;
        ctl_o.div_sel = DIV_LEFT;
        if (stat_i.div_done) begin
          state_d = ST_RGAIN;
        end
      end
      ST_RGAIN: begin
        ctl_o.div_go  = 1'b1;
        ctl_o.div_sel = DIV_RIGHT;
        if (stat_i.div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_ADDR: begin
        ctl_o.mod_go = 1'b1;
        if (stat_i.mod_done) begin
          state_d = ST_FIN;
        end
      end
      ST_VREAD: begin
        if (stat_i.cur_active) begin
          state_d = ST_VCHECK;
        end else begin
          ctl_o.v_next = 1'b1;
          state_d = stat_i.last_voice ? ST_FIN : ST_VREAD;
        end
      end
      ST_VCHECK: begin
        if (stat_i.expired) begin
          ctl_o.clr_active = 1'b1;
          ctl_o.v_next     = 1'b1;
          state_d = stat_i.last_voice ? ST_FIN : ST_VREAD;
        end else begin
          ctl_o.pos_wr = 1'b1;
          state_d = ST_VMOD;
        end
      end
      ST_VMOD: begin
        ctl_o.mod_go    = 1'b1;
        ctl_o.mod_voice = 1'b1;
        if (stat_i.mod_done) begin
          state_d = ST_SREAD;
        end
      end
      ST_SREAD: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        ctl_o.mul_en = 1'b1;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        ctl_o.acc_en = 1'b1;
        ctl_o.v_next = 1'b1;
        state_d = stat_i.last_voice ? ST_FIN : ST_VREAD;
      end
      ST_FIN: begin
        ctl_o.fin = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/pcmmix_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module pcmmix_dp
  import pcmmix_pkg::*;
#(
  parameter int VOICES       = 16,
  parameter int SAMPLE_DEPTH = 65536,
  parameter int OUTPUT_RATE  = 48000
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  ctl_t                      ctl_i,
  output stat_t                     stat_o,
  input  wire         [2:0]         cmd_i,
  input  wire         [VOICE_W-1:0] voice_i,
  input  wire         [ADDR_W-1:0]  address_i,
  input  wire         [BYTE_W-1:0]  byte_value_i,
  input  wire         [COUNT_W-1:0] sample_count_i,
  input  wire         [RATE_W-1:0]  native_rate_i,
  input  wire         [VOL_W-1:0]   volume_i,
  input  wire         [SEP_W-1:0]   separation_i,
  output logic signed [SAMP_W-1:0]  left_out_o,
  output logic signed [SAMP_W-1:0]  right_out_o,
  output logic                      status_o,
  output logic        [MASK_W-1:0]  active_mask_o,
  output logic                      result_valid_o
);

  localparam int VW        = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int AW        = $clog2(SAMPLE_DEPTH);
  localparam longint STEP_MAX = (64'd65535 << FRAC_W) / OUTPUT_RATE;
  localparam int STEP_W    = $clog2(STEP_MAX + 1);
  localparam int STEP_K    = DIV_W + $clog2(OUTPUT_RATE);
  localparam int STEP_SH   = STEP_K - FRAC_W;
  localparam int GAIN_K    = SEP_W + VOL_W + $clog2(GAIN_DIV);
  localparam int RCP_W     = DIV_W + 2;
  localparam int NUM_W     = RATE_W;
  localparam int QP_W      = NUM_W + RCP_W;
  localparam logic [RCP_W-1:0] STEP_RCP =
    RCP_W'(((64'd1 << STEP_K) + 64'(OUTPUT_RATE) - 64'd1) / 64'(OUTPUT_RATE));
  localparam logic [RCP_W-1:0] GAIN_RCP =
    RCP_W'(((64'd1 << GAIN_K) + 64'(GAIN_DIV) - 64'd1) / 64'(GAIN_DIV));
  localparam int MOD_IN_W  = ADDR_W + 1;
  localparam int MOD_STEPS = (AW >= MOD_IN_W) ? 1 : (MOD_IN_W - AW + 1);
  localparam int MJ_W      = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
  localparam int SH_W      = AW + MOD_STEPS + 1;
  localparam int PROD_W    = SAMP_W + GAIN_W + 1;
  localparam int SC_W      = PROD_W - GAIN_W;
  localparam int ACC_W     = SAMP_W + 1 + $clog2(VOICES + 1);
  localparam int MV        = (VOICES < MASK_W) ? VOICES : MASK_W;
  localparam int REC_W     = ADDR_W + COUNT_W + STEP_W;
  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(SAT_MAX);
  localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(SAT_MIN);

  // Request fields held for the whole operation.
  logic [2:0]         cmd_q;
  logic [VOICE_W-1:0] voice_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [BYTE_W-1:0]  byte_q;
  logic [COUNT_W-1:0] count_q;
  logic [RATE_W-1:0]  rate_q;
  logic [VOL_W-1:0]   vol_q;
  logic [SEP_W-1:0]   sep_q;
  logic               reject_q;
  logic               vok_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      cmd_q    <= cmd_i;
      voice_q  <= voice_i;
      addr_q   <= address_i;
      byte_q   <= byte_value_i;
      count_q  <= sample_count_i;
      rate_q   <= native_rate_i;
      vol_q    <= volume_i;
      sep_q    <= separation_i;
      reject_q <= (cmd_i == CMD_START) && (sample_count_i == '0);
      vok_q    <= stat_o.voice_ok_in;
    end
  end

  logic [VW-1:0] vidx;
  logic          fin_start;
  logic          fin_set;
  logic          fin_stop;
  logic          fin_load;
  logic          fin_mix;

  assign vidx      = VW'(voice_q);
  assign fin_start = ctl_i.fin && (cmd_q == CMD_START) && vok_q && !reject_q;
  assign fin_set   = ctl_i.fin && (cmd_q == CMD_SET) && vok_q;
  assign fin_stop  = ctl_i.fin && (cmd_q == CMD_STOP) && vok_q;
  assign fin_load  = ctl_i.fin && (cmd_q == CMD_LOAD);
  assign fin_mix   = ctl_i.fin && (cmd_q == CMD_MIX);

  // The step and the two pan gains divide by constants through a reciprocal multiply.
  // The numerator is registered first, and the quotient is then registered from it.
  logic [RATE_W-1:0]        rate_eff;
  logic [SEP_W-1:0]         sep_diff;
  logic [SEP_W+VOL_W-1:0]   lprod;
  logic [SEP_W+VOL_W-1:0]   rprod;
  logic [NUM_W-1:0]         div_num;
  logic [RCP_W-1:0]         div_rcp;
  logic [NUM_W-1:0]         div_num_q;
  logic [QP_W-1:0]          div_prod;
  logic                     div_busy_q;
  logic                     div_done;
  logic [STEP_W-1:0]        step_q;
  logic [GAIN_W-1:0]        lgain_q;
  logic [GAIN_W-1:0]        rgain_q;

  assign rate_eff = (rate_q == '0) ? RATE_W'(DEFAULT_RATE) : rate_q;
  assign sep_diff = SEP_W'(SEP_MAX) - sep_q;
  assign lprod    = (int'(sep_q) > SEP_MAX) ? '0 :
                    {{VOL_W{1'b0}}, sep_diff} * {{SEP_W{1'b0}}, vol_q};
  assign rprod    = {{VOL_W{1'b0}}, sep_q} * {{SEP_W{1'b0}}, vol_q};

  always_comb begin
    case (ctl_i.div_sel)
      DIV_STEP: begin
        div_num = rate_eff;
        div_rcp = STEP_RCP;
      end
      DIV_LEFT: begin
        div_num = NUM_W'(lprod);
        div_rcp = GAIN_RCP;
      end
      DIV_RIGHT: begin
        div_num = NUM_W'(rprod);
        div_rcp = GAIN_RCP;
      end
      default: begin
        div_num = '0;
        div_rcp = GAIN_RCP;
      end
    endcase
  end

  assign div_prod = {{RCP_W{1'b0}}, div_num_q} * {{NUM_W{1'b0}}, div_rcp};
  assign div_done = div_busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
    end else if (div_done) begin
      div_busy_q <= 1'b0;
    end else if (ctl_i.div_go) begin
      div_busy_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!div_busy_q && ctl_i.div_go) begin
      div_num_q <= div_num;
    end
    if (div_done) begin
      case (ctl_i.div_sel)
        DIV_STEP:  step_q  <= div_prod[STEP_SH +: STEP_W];
        DIV_LEFT:  lgain_q <= div_prod[GAIN_K +: GAIN_W];
        DIV_RIGHT: rgain_q <= div_prod[GAIN_K +: GAIN_W];
        default:   step_q  <= step_q;
      endcase
    end
  end

  // Voice records, positions and gains.
  logic [VW-1:0]     c_q;
  logic [VW-1:0]     waddr;
  logic [REC_W-1:0]  rec_mem [VOICES];
  logic [POS_W-1:0]  pos_mem [VOICES];
  logic [2*GAIN_W-1:0] gain_mem [VOICES];
  logic [REC_W-1:0]  rec_rd_q;
  logic [POS_W-1:0]  pos_rd_q;
  logic [2*GAIN_W-1:0] gain_rd_q;
  logic [ADDR_W-1:0] base_rd;
  logic [COUNT_W-1:0] len_rd;
  logic [STEP_W-1:0] step_rd;
  logic              pos_we;
  logic [POS_W-1:0]  pos_wdata;

  assign base_rd   = rec_rd_q[REC_W-1 -: ADDR_W];
  assign len_rd    = rec_rd_q[STEP_W +: COUNT_W];
  assign step_rd   = rec_rd_q[STEP_W-1:0];
  assign waddr     = ctl_i.fin ? vidx : c_q;
  assign pos_we    = fin_start || ctl_i.pos_wr;
  assign pos_wdata = fin_start ? '0 : (pos_rd_q + POS_W'(step_rd));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0;
    end else if (ctl_i.accept) begin
      c_q <= '0;
    end else if (ctl_i.v_next) begin
      c_q <= c_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_start) begin
      rec_mem[waddr] <= {addr_q, count_q, step_q};
    end
    rec_rd_q <= rec_mem[c_q];
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem[waddr] <= pos_wdata;
    end
    pos_rd_q <= pos_mem[c_q];
  end

  always_ff @(posedge clk_i) begin
    if (fin_start || fin_set) begin
      gain_mem[waddr] <= {lgain_q, rgain_q};
    end
    gain_rd_q <= gain_mem[c_q];
  end

  // Address wrap modulo the store depth by serial compare and subtract.
  logic [MOD_IN_W-1:0] mod_src;
  logic [MOD_IN_W-1:0] m_q;
  logic [MOD_IN_W-1:0] m_d;
  logic [MJ_W-1:0]     mj_q;
  logic                mod_busy_q;
  logic                mod_done;
  logic [SH_W-1:0]     shifted;
  logic                mod_ge;

  assign mod_src  = ctl_i.mod_voice ?
                    ({1'b0, base_rd} + {1'b0, pos_rd_q[POS_W-1 -: FRAC_W]}) :
                    {1'b0, addr_q};
  assign shifted  = SH_W'(SAMPLE_DEPTH) << mj_q;
  assign mod_ge   = (SH_W'(m_q) >= shifted);
  assign m_d      = mod_ge ? (m_q - MOD_IN_W'(shifted)) : m_q;
  assign mod_done = mod_busy_q && (mj_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_busy_q <= 1'b0;
      mj_q       <= '0;
    end else if (!mod_busy_q && ctl_i.mod_go) begin
      mod_busy_q <= 1'b1;
      mj_q       <= MJ_W'(MOD_STEPS - 1);
    end else if (mod_busy_q) begin
      if (mod_done) begin
        mod_busy_q <= 1'b0;
      end else begin
        mj_q <= mj_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!mod_busy_q && ctl_i.mod_go) begin
      m_q <= mod_src;
    end else if (mod_busy_q) begin
      m_q <= m_d;
    end
  end

  // Sample store.
  logic [BYTE_W-1:0] smem [SAMPLE_DEPTH];
  logic [BYTE_W-1:0] sdata_q;
  logic [AW-1:0]     saddr;

  assign saddr = AW'(m_q);

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      smem[saddr] <= byte_q;
    end
    sdata_q <= smem[saddr];
  end

  // Scale and accumulate.
  logic signed [SAMP_W-1:0] sample;
  logic signed [PROD_W-1:0] prod_l;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SC_W-1:0]   sc_l_q;
  logic signed [SC_W-1:0]   sc_r_q;
  logic signed [ACC_W-1:0]  acc_l_q;
  logic signed [ACC_W-1:0]  acc_r_q;

  // A byte b reads back as b*257-32768, which is the byte doubled with its top bit flipped.
  assign sample = {~sdata_q[BYTE_W-1], sdata_q[BYTE_W-2:0], sdata_q};
  assign prod_l = sample * $signed({1'b0, gain_rd_q[2*GAIN_W-1:GAIN_W]});
  assign prod_r = sample * $signed({1'b0, gain_rd_q[GAIN_W-1:0]});

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      sc_l_q <= prod_l[PROD_W-1:GAIN_W];
      sc_r_q <= prod_r[PROD_W-1:GAIN_W];
    end
    if (ctl_i.accept) begin
      acc_l_q <= '0;
      acc_r_q <= '0;
    end else if (ctl_i.acc_en) begin
      acc_l_q <= acc_l_q + {{(ACC_W-SC_W){sc_l_q[SC_W-1]}}, sc_l_q};
      acc_r_q <= acc_r_q + {{(ACC_W-SC_W){sc_r_q[SC_W-1]}}, sc_r_q};
    end
  end

  logic signed [SAMP_W-1:0] left_sat;
  logic signed [SAMP_W-1:0] right_sat;

  always_comb begin
    if (acc_l_q > ACC_MAX) begin
      left_sat = SAMP_W'(SAT_MAX);
    end else if (acc_l_q < ACC_MIN) begin
      left_sat = SAMP_W'(SAT_MIN);
    end else begin
      left_sat = acc_l_q[SAMP_W-1:0];
    end
    if (acc_r_q > ACC_MAX) begin
      right_sat = SAMP_W'(SAT_MAX);
    end else if (acc_r_q < ACC_MIN) begin
      right_sat = SAMP_W'(SAT_MIN);
    end else begin
      right_sat = acc_r_q[SAMP_W-1:0];
    end
  end

  // Voice activity.
  logic [VOICES-1:0] act_q;
  logic [VOICES-1:0] act_d;
  logic [MASK_W-1:0] mask;

  always_comb begin
    act_d = act_q;
    if (ctl_i.clr_active) begin
      act_d[c_q] = 1'b0;
    end
    if (fin_start) begin
      act_d[vidx] = 1'b1;
    end
    if (fin_stop) begin
      act_d[vidx] = 1'b0;
    end
    mask = '0;
    mask[MV-1:0] = act_d[MV-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q          <= '0;
      result_valid_o <= 1'b0;
    end else begin
      act_q          <= act_d;
      result_valid_o <= ctl_i.fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.fin) begin
      left_out_o    <= fin_mix ? left_sat : '0;
      right_out_o   <= fin_mix ? right_sat : '0;
      status_o      <= reject_q;
      active_mask_o <= mask;
    end
  end

  always_comb begin
    stat_o.cmd_in        = cmd_i;
    stat_o.count_zero_in = (sample_count_i == '0);
    stat_o.voice_ok_in   = (int'(voice_i) < VOICES);
    stat_o.div_done      = div_done;
    stat_o.mod_done      = mod_done;
    stat_o.cur_active    = act_q[c_q];
    stat_o.expired       = (pos_rd_q[POS_W-1 -: FRAC_W] >= len_rd);
    stat_o.last_voice    = (c_q == VW'(VOICES - 1));
  end

endmodule

`default_nettype wire

// File: sim/multi_voice_pcm_mixer_core_tb.sv
`timescale 1ns / 1ps

module multi_voice_pcm_mixer_core_tb;
  import pcmmix_pkg::*;

  localparam int NUM_VOICES  = 16;
  localparam int OUT_RATE    = 48000;
  localparam int GAIN_MAX    = 255;
  localparam int QUIET_LIMIT = 3000;
  localparam int PHASE_ITEMS = 345;

  localparam logic [2:0] CMD_SPARE_MIN = 3'(CMD_MIX + 1);
  localparam logic [2:0] CMD_SPARE_MAX = '1;

  typedef struct {
    logic [2:0]         cmd;
    logic [VOICE_W-1:0] voice;
    logic [ADDR_W-1:0]  address;
    logic [BYTE_W-1:0]  byte_value;
    logic [COUNT_W-1:0] sample_count;
    logic [RATE_W-1:0]  native_rate;
    logic [VOL_W-1:0]   volume;
    logic [SEP_W-1:0]   separation;
  } mix_req_t;

  typedef struct {
    logic signed [SAMP_W-1:0] left;
    logic signed [SAMP_W-1:0] right;
    logic                     status;
    logic [MASK_W-1:0]        mask;
  } mix_reply_t;

  class mixer_shadow;
    logic [BYTE_W-1:0]  store_bytes [1 << ADDR_W];
    bit                 written     [1 << ADDR_W];
    logic [ADDR_W-1:0]  base_addr   [NUM_VOICES];
    logic [COUNT_W-1:0] sound_len   [NUM_VOICES];
    logic [POS_W-1:0]   position    [NUM_VOICES];
    logic [16:0]        step        [NUM_VOICES];
    logic [GAIN_W-1:0]  gain_l      [NUM_VOICES];
    logic [GAIN_W-1:0]  gain_r      [NUM_VOICES];
    bit                 playing     [NUM_VOICES];
    mix_reply_t         awaited_replies [$];
    int                 errors;

    function new();
      for (int c = 0; c < NUM_VOICES; c++) begin
        base_addr[c] = '0;
        sound_len[c] = '0;
        position[c]  = '0;
        step[c]      = '0;
        gain_l[c]    = '0;
        gain_r[c]    = '0;
        playing[c]   = 1'b0;
      end
      errors = 0;
    endfunction

    function bit next_read(int c, output logic [ADDR_W-1:0] a);
      logic [POS_W-1:0] idx;
      idx = position[c] >> FRAC_W;
      a = base_addr[c] + idx[ADDR_W-1:0];
      return playing[c] && (idx < sound_len[c]);
    endfunction

    function void load_gains(int c, int vol, int sep);
      int l;
      int r;
      l = (sep > SEP_MAX) ? 0 : ((SEP_MAX - sep) * vol) / GAIN_DIV;
      r = (sep * vol) / GAIN_DIV;
      gain_l[c] = GAIN_W'((l > GAIN_MAX) ? GAIN_MAX : l);
      gain_r[c] = GAIN_W'((r > GAIN_MAX) ? GAIN_MAX : r);
    endfunction

    function logic signed [SAMP_W-1:0] sat16(int x);
      if (x > SAT_MAX) return SAMP_W'(SAT_MAX);
      if (x < SAT_MIN) return SAMP_W'(SAT_MIN);
      return SAMP_W'(x);
    endfunction

    function void note_request(mix_req_t rq);
      mix_reply_t        rp;
      int                acc_l;
      int                acc_r;
      int                sample;
      int                rate;
      logic [ADDR_W-1:0] a;
      rp = '{default: '0};
      acc_l = 0;
      acc_r = 0;
      case (rq.cmd)
        CMD_LOAD: begin
          store_bytes[rq.address] = rq.byte_value;
          written[rq.address] = 1'b1;
        end
        CMD_START: begin
          if (rq.sample_count == 0) begin
            rp.status = 1'b1;
          end else begin
            rate = (rq.native_rate == 0) ? DEFAULT_RATE : int'(rq.native_rate);
            base_addr[rq.voice] = rq.address;
            sound_len[rq.voice] = rq.sample_count;
            position[rq.voice]  = '0;
            step[rq.voice]      = 17'((longint'(rate) << FRAC_W) / OUT_RATE);
            load_gains(rq.voice, rq.volume, rq.separation);
            playing[rq.voice]   = 1'b1;
          end
        end
        CMD_SET: load_gains(rq.voice, rq.volume, rq.separation);
        CMD_STOP: playing[rq.voice] = 1'b0;
        CMD_MIX: begin
          for (int c = 0; c < NUM_VOICES; c++) begin
            if (!playing[c]) continue;
            if (!next_read(c, a)) begin
              playing[c] = 1'b0;
              continue;
            end
            sample = int'(store_bytes[a]) * 257 - 32768;
            acc_l += (sample * int'(gain_l[c])) >>> 8;
            acc_r += (sample * int'(gain_r[c])) >>> 8;
            position[c] += step[c];
          end
          rp.left  = sat16(acc_l);
          rp.right = sat16(acc_r);
        end
        default: ;
      endcase
      for (int c = 0; c < NUM_VOICES; c++) rp.mask[c] = playing[c];
      awaited_replies.push_back(rp);
    endfunction

    function void compare(string field, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic signed [SAMP_W-1:0] l, logic signed [SAMP_W-1:0] r,
                               logic st, logic [MASK_W-1:0] m);
      mix_reply_t rp;
      if (awaited_replies.size() == 0) begin
        $display("%0t: result with no request pending, expected none, got %0d %0d %0d %h",
                 $time, l, r, st, m);
        errors++;
        return;
      end
      rp = awaited_replies.pop_front();
      compare("left_out", rp.left, l);
      compare("right_out", rp.right, r);
      compare("status", rp.status, st);
      compare("active_mask", rp.mask, m);
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni         = 1'b0;
  logic               start          = 1'b0;
  logic               busy;
  logic [2:0]         cmd_i          = '0;
  logic [VOICE_W-1:0] voice_i        = '0;
  logic [ADDR_W-1:0]  address_i      = '0;
  logic [BYTE_W-1:0]  byte_value_i   = '0;
  logic [COUNT_W-1:0] sample_count_i = '0;
  logic [RATE_W-1:0]  native_rate_i  = '0;
  logic [VOL_W-1:0]   volume_i       = '0;
  logic [SEP_W-1:0]   separation_i   = '0;
  logic signed [SAMP_W-1:0] left_out_o;
  logic signed [SAMP_W-1:0] right_out_o;
  logic               status_o;
  logic [MASK_W-1:0]  active_mask_o;
  logic               result_valid_o;

  mixer_shadow shadow;
  int          idle_pct    = 0;
  int          sent        = 0;
  int          quiet_count = 0;

  multi_voice_pcm_mixer_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .voice_i       (voice_i),
    .address_i     (address_i),
    .byte_value_i  (byte_value_i),
    .sample_count_i(sample_count_i),
    .native_rate_i (native_rate_i),
    .volume_i      (volume_i),
    .separation_i  (separation_i),
    .left_out_o    (left_out_o),
    .right_out_o   (right_out_o),
    .status_o      (status_o),
    .active_mask_o (active_mask_o),
    .result_valid_o(result_valid_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      shadow.check_result(left_out_o, right_out_o, status_o, active_mask_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
      if (quiet_count >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic mix_req_t noise_req();
    mix_req_t rq;
    rq.cmd          = CMD_MIX;
    rq.voice        = VOICE_W'($urandom);
    rq.address      = ADDR_W'($urandom);
    rq.byte_value   = BYTE_W'($urandom);
    rq.sample_count = COUNT_W'($urandom);
    rq.native_rate  = RATE_W'($urandom);
    rq.volume       = VOL_W'($urandom);
    rq.separation   = SEP_W'($urandom);
    return rq;
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    if ($urandom_range(99) < 30) return $urandom_range(1) ? 8'hFF : 8'h00;
    return BYTE_W'($urandom);
  endfunction

  task automatic issue(input mix_req_t rq);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    cmd_i          <= rq.cmd;
    voice_i        <= rq.voice;
    address_i      <= rq.address;
    byte_value_i   <= rq.byte_value;
    sample_count_i <= rq.sample_count;
    native_rate_i  <= rq.native_rate;
    volume_i       <= rq.volume;
    separation_i   <= rq.separation;
    start          <= 1'b1;
    do @(posedge clk_i); while (busy);
    shadow.note_request(rq);
    sent++;
  endtask

  task automatic load_byte(input logic [ADDR_W-1:0] a, input logic [BYTE_W-1:0] b);
    mix_req_t rq;
    rq = noise_req();
    rq.cmd = CMD_LOAD;
    rq.address = a;
    rq.byte_value = b;
    issue(rq);
  endtask

  task automatic start_voice(input logic [VOICE_W-1:0] v, input logic [ADDR_W-1:0] base,
                             input logic [COUNT_W-1:0] count, input logic [RATE_W-1:0] rate,
                             input logic [VOL_W-1:0] vol, input logic [SEP_W-1:0] sep);
    mix_req_t rq;
    rq = noise_req();
    rq.cmd = CMD_START;
    rq.voice = v;
    rq.address = base;
    rq.sample_count = count;
    rq.native_rate = rate;
    rq.volume = vol;
    rq.separation = sep;
    issue(rq);
  endtask

  task automatic set_voice(input logic [VOICE_W-1:0] v, input logic [VOL_W-1:0] vol,
                           input logic [SEP_W-1:0] sep);
    mix_req_t rq;
    rq = noise_req();
    rq.cmd = CMD_SET;
    rq.voice = v;
    rq.volume = vol;
    rq.separation = sep;
    issue(rq);
  endtask

  task automatic control(input logic [2:0] c, input logic [VOICE_W-1:0] v);
    mix_req_t rq;
    rq = noise_req();
    rq.cmd = c;
    rq.voice = v;
    issue(rq);
  endtask

  // Every byte that the next frame will read is stored first.
  task automatic play_frame();
    logic [ADDR_W-1:0] a;
    for (int c = 0; c < NUM_VOICES; c++) begin
      if (shadow.next_read(c, a) && !shadow.written[a]) load_byte(a, pick_byte());
    end
    control(CMD_MIX, VOICE_W'($urandom));
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (shadow.awaited_replies.size() != 0);
  endtask

  task automatic random_item();
    int                 pick;
    logic [ADDR_W-1:0]  base;
    logic [COUNT_W-1:0] count;
    logic [RATE_W-1:0]  rate;
    logic [VOL_W-1:0]   vol;
    logic [SEP_W-1:0]   sep;
    pick = $urandom_range(99);
    if (pick < 34) begin
      play_frame();
    end else if (pick < 54) begin
      base = ($urandom_range(99) < 30) ? ADDR_W'(16'hFF00 | $urandom_range(255))
                                       : ADDR_W'($urandom);
      pick = $urandom_range(99);
      count = (pick < 80) ? COUNT_W'($urandom_range(1, 24)) :
              (pick < 95) ? COUNT_W'($urandom) : '0;
      pick = $urandom_range(99);
      case ($urandom_range(5))
        0: rate = 16'd8000;
        1: rate = 16'd11025;
        2: rate = 16'd22050;
        3: rate = 16'd44100;
        4: rate = 16'd48000;
        default: rate = 16'hFFFF;
      endcase
      if (pick < 10) rate = '0;
      else if (pick < 80) rate = RATE_W'($urandom);
      pick = $urandom_range(99);
      vol = (pick < 20) ? '1 : (pick < 30) ? '0 : VOL_W'($urandom);
      case ($urandom_range(3))
        0: sep = 8'd0;
        1: sep = 8'd128;
        2: sep = 8'd254;
        default: sep = 8'd255;
      endcase
      if ($urandom_range(99) >= 15) sep = SEP_W'($urandom);
      start_voice(VOICE_W'($urandom), base, count, rate, vol, sep);
    end else if (pick < 72) begin
      load_byte(ADDR_W'($urandom), pick_byte());
    end else if (pick < 84) begin
      set_voice(VOICE_W'($urandom), VOL_W'($urandom), SEP_W'($urandom));
    end else if (pick < 94) begin
      control(CMD_STOP, VOICE_W'($urandom));
    end else begin
      control(3'($urandom_range(CMD_SPARE_MIN, CMD_SPARE_MAX)), VOICE_W'($urandom));
    end
  endtask

  initial begin
    int idle_by_phase [4] = '{0, 49, 0, 21};
    int phase_end;
    shadow = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    play_frame();
    control(CMD_STOP, 4'd0);
    set_voice(4'd3, 7'd127, 8'd255);
    start_voice(4'd15, 16'h1234, 16'd0, 16'd0, 7'd127, 8'd128);
    control(CMD_SPARE_MIN, 4'd5);
    control(CMD_SPARE_MAX, 4'd9);
    load_byte(16'hFFFF, 8'hFF);
    load_byte(16'h0000, 8'hFF);
    load_byte(16'h0001, 8'hFF);
    start_voice(4'd0, 16'hFFFF, 16'd3, 16'd0, 7'd127, 8'd255);
    start_voice(4'd1, 16'hFFFF, 16'd2, 16'hFFFF, 7'd127, 8'd0);
    start_voice(4'd2, 16'hFFFF, 16'd1, 16'd48000, 7'd127, 8'd128);
    play_frame();
    play_frame();
    start_voice(4'd0, 16'hFFFF, 16'd3, 16'd0, 7'd127, 8'd255);
    set_voice(4'd1, 7'd0, 8'd0);
    control(CMD_STOP, 4'd2);
    load_byte(16'h8000, 8'h00);
    start_voice(4'd3, 16'h8000, 16'd1, 16'd48000, 7'd127, 8'd0);
    start_voice(4'd4, 16'h8000, 16'd1, 16'd48000, 7'd127, 8'd128);
    repeat (5) play_frame();
    drain();

    foreach (idle_by_phase[p]) begin
      idle_pct = idle_by_phase[p];
      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end) random_item();
      drain();
    end

    repeat (200) @(posedge clk_i);
    if (shadow.errors == 0 && shadow.awaited_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/pcmmix_pkg.sv
rtl/pcmmix_ctrl.sv
rtl/pcmmix_dp.sv
rtl/multi_voice_pcm_mixer_core.sv
sim/multi_voice_pcm_mixer_core_tb.sv
